### src/sos_pkg.sv
package sos_pkg;

  localparam int SAMPLES  = 91;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int ANGLE_W  = 8;
  localparam int DIST_W   = 16;
  localparam int WIDTH_W  = 17;
  localparam int CNT_W    = 4;
  localparam int HALF_W   = 7;
  localparam int ROM_LAST = 90;
  localparam int CFG_W    = 17;
  localparam int ROUND_SHIFT = 14;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 56;
  localparam int OUT_BITS    = CNT_W + 2 * ANGLE_W + DIST_W + WIDTH_W;

  localparam logic [ANGLE_W-1:0] LAST_ANGLE = ANGLE_W'(2 * (SAMPLES - 1));

  localparam logic [DIST_W-1:0]  RANGE_LIMIT_RST = 16'd2400;
  localparam logic [DIST_W-1:0]  JUMP_LIMIT_RST  = 16'd160;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 17'd32;
  localparam logic [CNT_W-1:0]   MAX_OBJECTS_RST = 4'd9;

  typedef enum logic [1:0] {
    REG_RANGE_LIMIT = 2'd0,
    REG_JUMP_LIMIT  = 2'd1,
    REG_MIN_WIDTH   = 2'd2,
    REG_MAX_OBJECTS = 2'd3
  } cfg_reg_e;

  // round(sin(k deg) * 32768), k = 0..90
  localparam logic [15:0] SINE_ROM [0:ROM_LAST] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
    16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
    16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
    16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
    16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
    16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
    16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28933, 16'd29197, 16'd29452,
    16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
    16'd31164, 16'd31336, 16'd31499, 16'd31652, 16'd31795, 16'd31928, 16'd32052,
    16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
    16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] first_angle;
    logic [ANGLE_W-1:0] stop_angle;
    logic [DIST_W-1:0]  nearest;
    logic [HALF_W-1:0]  half;
  } cand_t;

  function automatic cand_t make_cand(logic [ANGLE_W-1:0] first_ang,
                                      logic [ANGLE_W-1:0] stop_angle,
                                      logic [DIST_W-1:0] nearest);
    cand_t              c;
    logic [ANGLE_W-1:0] span;
    logic [HALF_W-1:0]  h;
    span = (stop_angle >= first_ang) ? stop_angle - first_ang : '0;
    h    = span[ANGLE_W-1:1];
    c.first_angle = first_ang;
    c.stop_angle  = stop_angle;
    c.nearest     = nearest;
    c.half        = (h > HALF_W'(ROM_LAST)) ? HALF_W'(ROM_LAST) : h;
    return c;
  endfunction

  function automatic logic [WIDTH_W-1:0] chord_width(logic [DIST_W-1:0] d,
                                                     logic [HALF_W-1:0] h);
    logic [31:0] p;
    p = 32'(d) * 32'(SINE_ROM[h]) + 32'(1 << (ROUND_SHIFT - 1));
    return p[ROUND_SHIFT +: WIDTH_W];
  endfunction

endpackage

### src/scan_object_segmenter_core.sv
// Range-scan object segmenter.
// s_axis: one range sample per item, tdata[15:0] = distance (Q12.4 cm).
//   A sweep is SAMPLES items, sample i at angle 2*i degrees.
// m_axis: one item per object that is closed and qualifies; tlast marks the
//   last result caused by one input sample (a sweep's final sample may cause two).
// cfg: write channel, cfg_addr_i selects range_limit, jump_limit, min_width,
//   max_objects; always ready. Write only while no sample is in flight.
// Pipeline: a result reaches m_axis through the segmentation register, the
//   chord-width multiply register and the output register, in that order.
// Throughput: one sample per cycle while m_axis does not stall. A sweep's final
//   sample that closes two objects holds the width stage while it releases them, one result per cycle.
// Reset: registers return to their defaults, the sweep restarts at sample 0
//   with no open object and an object count of zero.
// When m_axis stalls, the output register holds its item; the width and
//   segmentation stages fill behind it and s_axis_tready drops once both are full.
module scan_object_segmenter_core
  import sos_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [15:0] distance
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] object_number, [11:4] first_angle, [19:12] final_angle,
  // [35:20] nearest_distance, [52:36] object_width, [55:53] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // last_of_run
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic [DIST_W-1:0]  range_limit_q, jump_limit_q;
  logic [WIDTH_W-1:0] min_width_q;
  logic [CNT_W-1:0]   max_objects_q;

  logic               inside_q, inside_d;
  logic [DIST_W-1:0]  prev_q;
  logic [ANGLE_W-1:0] start_q, start_d;
  logic [DIST_W-1:0]  near_q, near_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  logic               p1_valid_q, p1_c0_q, p1_c1_q, p1_end_q;
  cand_t              p1_cand0_q, p1_cand1_q;

  logic               p2_valid_q, p2_pend0_q, p2_pend1_q, p2_end_q;
  cand_t              p2_cand0_q, p2_cand1_q;
  logic [WIDTH_W-1:0] p2_w0_q, p2_w1_q;

  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic                   o_valid_q;
  logic [OUT_BITS-1:0]    o_data_q;
  logic                   o_last_q;

  logic               s_acc, p1_ready, p2_ready, p2_done, o_free;
  logic [DIST_W-1:0]  d_in, diff;
  logic [ANGLE_W-1:0] angle, prev_angle;
  logic               is_near, jump, c0_v, c1_v, last_sample;
  cand_t              cand0, cand1;

  logic               cur0, cur_pend, cur_q, cur_go, emit, nxt_q1;
  cand_t              cur_cand;
  logic [WIDTH_W-1:0] cur_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_limit_q <= RANGE_LIMIT_RST;
      jump_limit_q  <= JUMP_LIMIT_RST;
      min_width_q   <= MIN_WIDTH_RST;
      max_objects_q <= MAX_OBJECTS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_RANGE_LIMIT: range_limit_q <= cfg_data_i[DIST_W-1:0];
        REG_JUMP_LIMIT:  jump_limit_q  <= cfg_data_i[DIST_W-1:0];
        REG_MIN_WIDTH:   min_width_q   <= cfg_data_i[WIDTH_W-1:0];
        REG_MAX_OBJECTS: max_objects_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // Segmentation of the incoming sample
  assign d_in        = s_axis_tdata[DIST_W-1:0];
  assign angle       = ANGLE_W'({idx_q, 1'b0});
  assign prev_angle  = (angle >= ANGLE_W'(2)) ? angle - ANGLE_W'(2) : '0;
  assign diff        = (d_in >= prev_q) ? d_in - prev_q : prev_q - d_in;
  assign is_near     = d_in < range_limit_q;
  assign jump        = diff >= jump_limit_q;
  assign last_sample = (32'(idx_q) + 32'd1) >= 32'(SAMPLES);
  assign c0_v        = inside_q && (!is_near || jump);

  always_comb begin
    inside_d = inside_q;
    start_d  = start_q;
    near_d   = near_q;
    if (is_near) begin
      if (!inside_q || jump) begin
        start_d  = angle;
        near_d   = d_in;
        inside_d = 1'b1;
      end else if (d_in < near_q) begin
        near_d = d_in;
      end
    end else begin
      inside_d = 1'b0;
    end
  end

  assign c1_v  = last_sample && inside_d;
  assign cand0 = make_cand(start_q, prev_angle, near_q);
  assign cand1 = make_cand(start_d, LAST_ANGLE, near_d);
  assign idx_d = last_sample ? '0 : idx_q + IDX_W'(1);

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = p1_ready;
  assign p1_ready      = !p1_valid_q || p2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      prev_q   <= '0;
      start_q  <= '0;
      near_q   <= '0;
      idx_q    <= '0;
    end else if (s_acc) begin
      inside_q <= inside_d && !last_sample;
      prev_q   <= d_in;
      start_q  <= start_d;
      near_q   <= near_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (s_acc) begin
      p1_valid_q <= 1'b1;
    end else if (p2_ready) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_c0_q    <= c0_v;
      p1_c1_q    <= c1_v;
      p1_end_q   <= last_sample;
      p1_cand0_q <= cand0;
      p1_cand1_q <= cand1;
    end
  end

  // Width stage: release one closed object per cycle while m_axis does not stall
  assign cur0     = p2_pend0_q;
  assign cur_pend = p2_pend0_q || p2_pend1_q;
  assign cur_cand = cur0 ? p2_cand0_q : p2_cand1_q;
  assign cur_w    = cur0 ? p2_w0_q : p2_w1_q;
  assign cur_q    = (cur_w > min_width_q) && (cnt_q < max_objects_q);
  assign o_free   = !o_valid_q || m_axis_tready;
  assign cur_go   = p2_valid_q && cur_pend && (!cur_q || o_free);
  assign emit     = cur_go && cur_q;
  assign nxt_q1   = p2_pend1_q && (p2_w1_q > min_width_q)
                    && ((5'(cnt_q) + 5'd1) < 5'(max_objects_q));
  assign p2_done  = p2_valid_q
                    && (!cur_pend || (cur_go && !(p2_pend0_q && p2_pend1_q)));
  assign p2_ready = !p2_valid_q || p2_done;

  always_comb begin
    cnt_d = cnt_q;
    if (p2_done && p2_end_q) begin
      cnt_d = '0;
    end else if (emit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
      p2_pend0_q <= 1'b0;
      p2_pend1_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (p2_ready) begin
        p2_valid_q <= p1_valid_q;
        p2_pend0_q <= p1_valid_q && p1_c0_q;
        p2_pend1_q <= p1_valid_q && p1_c1_q;
      end else if (cur_go) begin
        if (cur0) begin
          p2_pend0_q <= 1'b0;
        end else begin
          p2_pend1_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_ready && p1_valid_q) begin
      p2_end_q   <= p1_end_q;
      p2_cand0_q <= p1_cand0_q;
      p2_cand1_q <= p1_cand1_q;
      p2_w0_q    <= chord_width(p1_cand0_q.nearest, p1_cand0_q.half);
      p2_w1_q    <= chord_width(p1_cand1_q.nearest, p1_cand1_q.half);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (emit) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_data_q <= {cur_w, cur_cand.nearest, cur_cand.stop_angle,
                   cur_cand.first_angle, cnt_q};
      o_last_q <= cur0 ? !nxt_q1 : 1'b1;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = TDATA_OUT_W'(o_data_q);
  assign m_axis_tlast  = o_last_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) < SAMPLES)
    else $error("sample index beyond sweep");

  a_second_close_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q && p2_pend1_q |-> p2_end_q)
    else $error("end-of-sweep close without final sample");

  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_done && p2_end_q |=> cnt_q == '0)
    else $error("object count not cleared at sweep end");

  a_number_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> cnt_q < max_objects_q)
    else $error("object emitted beyond limit");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !p1_valid_q |-> s_axis_tready)
    else $error("input stalled with empty segmentation stage");

endmodule
